// ===== rtl/core/lphi_pkg.sv =====
package lphi_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 31;
  localparam int STEP_W      = $clog2(KEY_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_t;

  localparam logic INS_STORED = 1'b0;
  localparam logic INS_FULL   = 1'b1;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/core/linear_probe_hash_insert_top.sv =====
// Linear-probing hash insert over TABLE_DEPTH slots held as occupancy flags.
// The key first goes to the bit-serial remainder unit for its home slot, then occupied
//   slots are probed upward; k = occupied slots skipped (0..S, S when full).
// One item at a time, next start taken in the strobe cycle; busy is high
//   from acceptance until the strobe, which lasts one cycle (the receiver cannot stall).
// Reset (rst_n low, synchronous): all slots empty, table_size = 16, idle.
module linear_probe_hash_insert_top
  import lphi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // item beat
  input  logic              start,
  output logic              busy,
  input  logic [KEY_W-1:0]  in_key_value,
  // result beat
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_stored_slot,
  output logic [SLOT_W-1:0] out_home_slot,
  output logic [SIZE_W-1:0] out_probe_count,
  output logic              out_insert_status,
  // table_size register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_table_size
);

  logic [SIZE_W-1:0] tsize_r, tsize_nxt;
  logic [SIZE_W-1:0] eff_size;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // table_size writes only while no item is in flight
  assign cfg_ready = !busy;

  always_comb begin
    tsize_nxt = tsize_r;
    if (cfg_valid && cfg_ready) begin
      tsize_nxt = cfg_table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= SIZE_W'(TABLE_DEPTH);
    end else begin
      tsize_r <= tsize_nxt;
    end
  end

  // clamp to 1..TABLE_DEPTH: zero acts as one, oversize as the full table
  always_comb begin
    if (tsize_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (tsize_r > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = tsize_r;
    end
  end

  // remainder unit: key mod S gives the home slot
  lphi_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req),
    .rsp     (mod_rsp)
  );

  // sequencer: hash, then probe upward one slot per cycle with wrap
  lphi_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .key               (in_key_value),
    .size              (eff_size),
    .busy              (busy),
    .mod_req           (mod_req),
    .mod_rsp           (mod_rsp),
    .out_valid         (out_valid),
    .out_stored_slot   (out_stored_slot),
    .out_home_slot     (out_home_slot),
    .out_probe_count   (out_probe_count),
    .out_insert_status (out_insert_status)
  );

`ifndef SYNTH
  a_eff_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    eff_size != '0 && eff_size <= SIZE_W'(TABLE_DEPTH))
    else $error("effective table size out of range");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
  a_home_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_home_slot} < eff_size)
    else $error("home slot outside table in use");
`endif

endmodule

// ===== rtl/core/lphi_mod.sv =====
module lphi_mod
  import lphi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  // restoring remainder, one key bit per cycle, MSB first
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0] div_r, div_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;

  assign trial = {rem_r, key_r[KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    key_nxt  = key_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(KEY_W - 1);
      key_nxt  = req.key;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      key_nxt = {key_r[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SIZE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[SIZE_W-1:0];
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    key_r  <= key_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a running division");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < div_r)
    else $error("remainder not below divisor");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("remainder unit restarted while running");
`endif

endmodule

// ===== rtl/core/lphi_ctrl.sv =====
module lphi_ctrl
  import lphi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [SIZE_W-1:0] size,
  output logic              busy,
  output mod_req_t          mod_req,
  input  mod_rsp_t          mod_rsp,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_stored_slot,
  output logic [SLOT_W-1:0] out_home_slot,
  output logic [SIZE_W-1:0] out_probe_count,
  output logic              out_insert_status
);

  state_t state_r, state_nxt;

  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      home_r, home_nxt;
  logic [SIZE_W-1:0]      cnt_r, cnt_nxt;

  logic              oval_r, oval_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  logic [SLOT_W-1:0] ohome_r, ohome_nxt;
  logic [SIZE_W-1:0] ocnt_r, ocnt_nxt;
  logic              ostat_r, ostat_nxt;

  logic accept, full_hit, free_hit;

  assign accept   = start && (state_r == ST_IDLE);
  assign full_hit = (cnt_r == size_r);
  assign free_hit = !full_hit && !occ_r[slot_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_HASH;
      ST_HASH:  if (mod_rsp.done) state_nxt = ST_PROBE;
      ST_PROBE: if (full_hit || free_hit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    occ_nxt   = occ_r;
    key_nxt   = key_r;
    size_nxt  = size_r;
    slot_nxt  = slot_r;
    home_nxt  = home_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = 1'b0;
    oslot_nxt = oslot_r;
    ohome_nxt = ohome_r;
    ocnt_nxt  = ocnt_r;
    ostat_nxt = ostat_r;
    mod_req.start   = accept;
    mod_req.key     = key;
    mod_req.divisor = size;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt  = key;
          size_nxt = size;
        end
      end
      ST_HASH: begin
        if (mod_rsp.done) begin
          home_nxt = mod_rsp.rem[SLOT_W-1:0];
          slot_nxt = mod_rsp.rem[SLOT_W-1:0];
          cnt_nxt  = '0;
        end
      end
      ST_PROBE: begin
        if (full_hit) begin
          oval_nxt  = 1'b1;
          oslot_nxt = '0;
          ohome_nxt = home_r;
          ocnt_nxt  = size_r;
          ostat_nxt = INS_FULL;
        end else if (free_hit) begin
          occ_nxt[slot_r] = (key_r != '0);
          oval_nxt  = 1'b1;
          oslot_nxt = slot_r;
          ohome_nxt = home_r;
          ocnt_nxt  = cnt_r;
          ostat_nxt = INS_STORED;
        end else begin
          cnt_nxt = cnt_r + SIZE_W'(1);
          if (({1'b0, slot_r} + SIZE_W'(1)) >= size_r) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      oval_r  <= oval_nxt;
    end
    key_r   <= key_nxt;
    size_r  <= size_nxt;
    slot_r  <= slot_nxt;
    home_r  <= home_nxt;
    cnt_r   <= cnt_nxt;
    oslot_r <= oslot_nxt;
    ohome_r <= ohome_nxt;
    ocnt_r  <= ocnt_nxt;
    ostat_r <= ostat_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = oval_r;
  assign out_stored_slot   = oslot_r;
  assign out_home_slot     = ohome_r;
  assign out_probe_count   = ocnt_r;
  assign out_insert_status = ostat_r;

`ifndef SYNTH
  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> state_r == ST_IDLE)
    else $error("result strobe while an item is still in flight");
  a_probe_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> cnt_r <= size_r && {1'b0, slot_r} < size_r)
    else $error("probe ran past the table in use");
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && ostat_r == INS_FULL |-> ocnt_r == size_r && oslot_r == '0)
    else $error("full status with wrong slot or count");
  a_one_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && ostat_r == INS_STORED |-> $countones(occ_r ^ $past(occ_r)) <= 1)
    else $error("insert changed more than one slot");
`endif

endmodule
